// ----- rtl/geodesic_window_filter_check_unit_assert.svh -----
// ----------------------------------------------------------------------------
// geodesic window filter check assertion macros
// shared concurrent assertion forms, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef GEODESIC_WINDOW_FILTER_CHECK_UNIT_ASSERT_SVH
`define GEODESIC_WINDOW_FILTER_CHECK_UNIT_ASSERT_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/gwfc_pkg.sv -----
// ----------------------------------------------------------------------------
// gwfc_pkg
// widths, constants and register map of the geodesic window filter check
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gwfc_pkg;

	localparam int FRAC_BITS       = 16;
	localparam int UNREACHED_UNITS = 10000;
	localparam int PROP_BITS       = 16;

	// field widths
	localparam int FLAGS_W = 2;
	localparam int LEN_W   = 31;
	localparam int PROP_W  = 17;
	localparam int COORD_W = 32;
	localparam int DIST_W  = 31;

	// flag bits
	localparam int FLAG_PSEUDO = 0;
	localparam int FLAG_LEFT   = 1;

	// datapath widths
	localparam int PROD_W  = PROP_W + LEN_W;
	localparam int POS_W   = PROD_W - PROP_BITS;
	localparam int DIFF_W  = POS_W + 3;
	localparam int MAG_W   = POS_W + 2;
	localparam int SQ_W    = 2 * MAG_W;
	localparam int SUM_W   = SQ_W + 1;
	localparam int ROOT_W  = (SUM_W + 1) / 2;
	localparam int CMP_W   = ROOT_W + 2;
	localparam int DETA_W  = ROOT_W + 2;
	localparam int DMAG_W  = DETA_W - 1;
	localparam int DSQ_W   = 2 * DMAG_W;

	// register map
	localparam int PADDR_W = 2;
	localparam int PDATA_W = 32;
	localparam logic [PADDR_W-1:0] ADDR_LIMIT = PADDR_W'(0);

	localparam longint LIMIT_RAW = longint'(UNREACHED_UNITS) << FRAC_BITS;
	localparam longint LIMIT_MAX = 64'h7FFF_FFFF;
	localparam logic [DIST_W-1:0] LIMIT_RESET =
		(LIMIT_RAW > LIMIT_MAX) ? DIST_W'(LIMIT_MAX) : DIST_W'(LIMIT_RAW);

endpackage

`default_nettype wire

// ----- rtl/gwfc_win_if.sv -----
// ----------------------------------------------------------------------------
// gwfc_win_if
// window channel: one propagation window with edge and vertex data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface gwfc_win_if;
	import gwfc_pkg::*;

	logic                      valid;
	logic                      ready;
	logic [FLAGS_W-1:0]        window_flags;
	logic [LEN_W-1:0]          edge_length;
	logic [PROP_W-1:0]         near_proportion;
	logic [PROP_W-1:0]         far_proportion;
	logic signed [COORD_W-1:0] source_x;
	logic signed [COORD_W-1:0] source_y;
	logic [DIST_W-1:0]         root_distance;
	logic [DIST_W-1:0]         left_vertex_dist;
	logic [DIST_W-1:0]         right_vertex_dist;
	logic [DIST_W-1:0]         opposite_vertex_dist;
	logic signed [COORD_W-1:0] opposite_x;
	logic signed [COORD_W-1:0] opposite_y;

	modport source (
		output valid, window_flags, edge_length, near_proportion, far_proportion,
		output source_x, source_y, root_distance, left_vertex_dist,
		output right_vertex_dist, opposite_vertex_dist, opposite_x, opposite_y,
		input  ready
	);

	modport sink (
		input  valid, window_flags, edge_length, near_proportion, far_proportion,
		input  source_x, source_y, root_distance, left_vertex_dist,
		input  right_vertex_dist, opposite_vertex_dist, opposite_x, opposite_y,
		output ready
	);

endinterface

`default_nettype wire

// ----- rtl/gwfc_res_if.sv -----
// ----------------------------------------------------------------------------
// gwfc_res_if
// result channel: keep or prune decision for one window
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface gwfc_res_if;
	logic valid;
	logic ready;
	logic keep_window;

	modport source (output valid, keep_window, input ready);
	modport sink (input valid, keep_window, output ready);

endinterface

`default_nettype wire

// ----- rtl/gwfc_square.sv -----
// ----------------------------------------------------------------------------
// gwfc_square
// two-stage unsigned squarer built from half-width partial products
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gwfc_square #(
	parameter int W = gwfc_pkg::MAG_W
) (
	input  logic           clk,
	input  logic           en,
	input  logic [W-1:0]   a,
	output logic [2*W-1:0] y
);
	localparam int LO_W = W / 2;
	localparam int HI_W = W - LO_W;

	logic [HI_W-1:0]      hi;
	logic [LO_W-1:0]      lo;
	logic [2*HI_W-1:0]    hh_s1;
	logic [HI_W+LO_W-1:0] hl_s1;
	logic [2*LO_W-1:0]    ll_s1;
	logic [2*W-1:0]       y_s2;

	assign hi = a[W-1:LO_W];
	assign lo = a[LO_W-1:0];

	always_ff @(posedge clk) begin
		if (en) begin
			hh_s1 <= (2*HI_W)'(hi) * (2*HI_W)'(hi);
			hl_s1 <= (HI_W+LO_W)'(hi) * (HI_W+LO_W)'(lo);
			ll_s1 <= (2*LO_W)'(lo) * (2*LO_W)'(lo);
		end
	end

	// (h*2^k + l)^2 = h^2*2^2k + 2hl*2^k + l^2
	always_ff @(posedge clk) begin
		if (en) begin
			y_s2 <= ((2*W)'(hh_s1) << (2*LO_W)) + ((2*W)'(hl_s1) << (LO_W+1))
				+ (2*W)'(ll_s1);
		end
	end

	assign y = y_s2;

endmodule

`default_nettype wire

// ----- rtl/gwfc_isqrt2.sv -----
// ----------------------------------------------------------------------------
// gwfc_isqrt2
// two-lane pipelined integer square root, one root bit per stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gwfc_isqrt2 #(
	parameter int SUM_W = gwfc_pkg::SUM_W,
	parameter int PW    = 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_valid,
	input  logic [SUM_W-1:0]           in_a,
	input  logic [SUM_W-1:0]           in_b,
	input  logic [PW-1:0]              in_pay,
	output logic                       out_valid,
	output logic [(SUM_W+1)/2-1:0]     root_a,
	output logic [(SUM_W+1)/2-1:0]     root_b,
	output logic [PW-1:0]              out_pay
);
	localparam int ROOT_W = (SUM_W + 1) / 2;
	localparam int RW     = 2 * ROOT_W + 1;

	logic              vld_s  [ROOT_W];
	logic [ROOT_W-1:0] ra_s   [ROOT_W];
	logic [ROOT_W-1:0] rb_s   [ROOT_W];
	logic [PW-1:0]     pay_s  [ROOT_W];
	logic [RW-1:0]     rema_s [ROOT_W-1];
	logic [RW-1:0]     remb_s [ROOT_W-1];

	genvar i;
	for (i = 0; i < ROOT_W; i++) begin : g_stage
		localparam int B = ROOT_W - 1 - i;

		logic              v_in;
		logic [ROOT_W-1:0] ra_in, rb_in;
		logic [RW-1:0]     rema_in, remb_in;
		logic [PW-1:0]     pay_in;
		logic [RW-1:0]     trial_a, trial_b;
		logic              take_a, take_b;

		if (i == 0) begin : g_first
			assign v_in    = in_valid;
			assign ra_in   = '0;
			assign rb_in   = '0;
			assign rema_in = RW'(in_a);
			assign remb_in = RW'(in_b);
			assign pay_in  = in_pay;
		end else begin : g_next
			assign v_in    = vld_s[i-1];
			assign ra_in   = ra_s[i-1];
			assign rb_in   = rb_s[i-1];
			assign rema_in = rema_s[i-1];
			assign remb_in = remb_s[i-1];
			assign pay_in  = pay_s[i-1];
		end

		// (r + 2^b)^2 - r^2 = r*2^(b+1) + 2^(2b)
		assign trial_a = (RW'(ra_in) << (B+1)) | (RW'(1) << (2*B));
		assign trial_b = (RW'(rb_in) << (B+1)) | (RW'(1) << (2*B));
		assign take_a  = (rema_in >= trial_a);
		assign take_b  = (remb_in >= trial_b);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (en) begin
				vld_s[i] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ra_s[i]  <= take_a ? (ra_in | (ROOT_W'(1) << B)) : ra_in;
				rb_s[i]  <= take_b ? (rb_in | (ROOT_W'(1) << B)) : rb_in;
				pay_s[i] <= pay_in;
			end
		end

		if (i < ROOT_W - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					rema_s[i] <= take_a ? (rema_in - trial_a) : rema_in;
					remb_s[i] <= take_b ? (remb_in - trial_b) : remb_in;
				end
			end
		end
	end

	assign out_valid = vld_s[ROOT_W-1];
	assign root_a    = ra_s[ROOT_W-1];
	assign root_b    = rb_s[ROOT_W-1];
	assign out_pay   = pay_s[ROOT_W-1];

endmodule

`default_nettype wire

// ----- rtl/geodesic_window_filter_check_unit.sv -----
// ----------------------------------------------------------------------------
// geodesic_window_filter_check_unit
// keep or prune decision for geodesic propagation windows
// ----------------------------------------------------------------------------
// Takes one window word per cycle on win and returns one keep_window word on
// res for each, in order. Both channels are valid/ready; a word moves on a
// clock edge with valid and ready high.
// From accept to res.valid a word passes the stages for positions and
// differences, the squarers, the sums, the bit-per-stage square root pipeline,
// the tests and the slack squarer, and 1 output reg.
// Throughput is one window per cycle while res.ready stays high.
// When the receiver stalls, a skid register takes one more finished word;
// once it is full the whole pipeline holds and win.ready drops, nothing is
// lost or repeated. After arst_n all stages are empty and unreached_limit
// holds 10000.0 in Q15.16. The limit is written over the APB port at byte
// address 0 and should only change while no window is in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module geodesic_window_filter_check_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	gwfc_win_if.sink                      win,
	gwfc_res_if.source                    res,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [gwfc_pkg::PADDR_W-1:0]  paddr,
	input  logic [gwfc_pkg::PDATA_W-1:0]  pwdata,
	output logic [gwfc_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready
);
	import gwfc_pkg::*;

	`include "geodesic_window_filter_check_unit_assert.svh"

	typedef struct packed {
		logic [FLAGS_W-1:0] flags;
		logic [LEN_W-1:0]   len;
		logic [POS_W-1:0]   pos0;
		logic [POS_W-1:0]   pos1;
		logic [DIST_W-1:0]  root;
		logic [DIST_W-1:0]  dl;
		logic [DIST_W-1:0]  dr;
		logic [DIST_W-1:0]  dop;
	} pre_t;

	typedef struct packed {
		pre_t             pre;
		logic [SUM_W-1:0] d2;
	} sq_pay_t;

	// configuration
	logic [DIST_W-1:0] limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (psel && penable && pwrite && paddr == ADDR_LIMIT) begin
			limit_q <= pwdata[DIST_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_LIMIT) ? PDATA_W'(limit_q) : '0;

	// global advance: pipeline moves while the skid register is free
	logic skid_valid_q;
	logic adv;

	assign adv       = !skid_valid_q;
	assign win.ready = adv;

	// stage 1: window positions along the edge
	logic [PROD_W-1:0] prod0, prod1;
	logic              v_s1;
	pre_t              pre_s1;
	logic signed [COORD_W-1:0] sx_s1, sy_s1, ox_s1, oy_s1;

	assign prod0 = PROD_W'(win.near_proportion) * PROD_W'(win.edge_length);
	assign prod1 = PROD_W'(win.far_proportion) * PROD_W'(win.edge_length);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= win.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pre_s1.flags <= win.window_flags;
			pre_s1.len   <= win.edge_length;
			pre_s1.pos0  <= prod0[PROD_W-1:PROP_BITS];
			pre_s1.pos1  <= prod1[PROD_W-1:PROP_BITS];
			pre_s1.root  <= win.root_distance;
			pre_s1.dl    <= win.left_vertex_dist;
			pre_s1.dr    <= win.right_vertex_dist;
			pre_s1.dop   <= win.opposite_vertex_dist;
			sx_s1        <= win.source_x;
			sy_s1        <= win.source_y;
			ox_s1        <= win.opposite_x;
			oy_s1        <= win.opposite_y;
		end
	end

	// stage 2: differences and their magnitudes
	logic signed [DIFF_W-1:0] sx_e, sy_e, ox_e, oy_e, len_e, pos0_e, pos1_e, psel_e;
	logic signed [DIFF_W-1:0] dx0, dx1, dxo;
	logic [MAG_W-1:0]         dx0m_s2, dx1m_s2, dxom_s2, sym_s2, oym_s2;
	logic                     v_s2;
	pre_t                     pre_s2;

	assign sx_e   = DIFF_W'(sx_s1);
	assign sy_e   = DIFF_W'(sy_s1);
	assign ox_e   = DIFF_W'(ox_s1);
	assign oy_e   = DIFF_W'(oy_s1);
	assign len_e  = DIFF_W'(pre_s1.len);
	assign pos0_e = DIFF_W'(pre_s1.pos0);
	assign pos1_e = DIFF_W'(pre_s1.pos1);
	assign psel_e = pre_s1.flags[FLAG_LEFT] ? pos0_e : pos1_e;
	assign dx0    = sx_e - pos0_e;
	assign dx1    = sx_e - pos1_e;
	// opposite vertex mapped to the edge frame, minus the chosen end
	assign dxo    = len_e - ox_e - psel_e;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dx0m_s2 <= MAG_W'(dx0[DIFF_W-1] ? -dx0 : dx0);
			dx1m_s2 <= MAG_W'(dx1[DIFF_W-1] ? -dx1 : dx1);
			dxom_s2 <= MAG_W'(dxo[DIFF_W-1] ? -dxo : dxo);
			sym_s2  <= MAG_W'(sy_e[DIFF_W-1] ? -sy_e : sy_e);
			oym_s2  <= MAG_W'(oy_e[DIFF_W-1] ? -oy_e : oy_e);
			pre_s2  <= pre_s1;
		end
	end

	// stages 3 and 4: squarers
	logic [SQ_W-1:0] dx0sq, dx1sq, dxosq, sysq, oysq;
	logic            v_s3, v_s4;
	pre_t            pre_s3, pre_s4;

	gwfc_square #(.W(MAG_W)) u_sq_dx0 (.clk(clk), .en(adv), .a(dx0m_s2), .y(dx0sq));
	gwfc_square #(.W(MAG_W)) u_sq_dx1 (.clk(clk), .en(adv), .a(dx1m_s2), .y(dx1sq));
	gwfc_square #(.W(MAG_W)) u_sq_dxo (.clk(clk), .en(adv), .a(dxom_s2), .y(dxosq));
	gwfc_square #(.W(MAG_W)) u_sq_sy  (.clk(clk), .en(adv), .a(sym_s2),  .y(sysq));
	gwfc_square #(.W(MAG_W)) u_sq_oy  (.clk(clk), .en(adv), .a(oym_s2),  .y(oysq));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pre_s3 <= pre_s2;
			pre_s4 <= pre_s3;
		end
	end

	// stage 5: squared distances
	logic [SUM_W-1:0] suml_s5, sumr_s5;
	logic             v_s5;
	sq_pay_t          pay_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			suml_s5    <= SUM_W'(dx0sq) + SUM_W'(sysq);
			sumr_s5    <= SUM_W'(dx1sq) + SUM_W'(sysq);
			pay_s5.pre <= pre_s4;
			pay_s5.d2  <= SUM_W'(dxosq) + SUM_W'(oysq);
		end
	end

	// stages 6 to 40: left and right lengths
	logic [ROOT_W-1:0] left_len, right_len;
	logic              v_s40;
	sq_pay_t           pay_s40;

	gwfc_isqrt2 #(
		.SUM_W (SUM_W),
		.PW    ($bits(sq_pay_t))
	) u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v_s5),
		.in_a      (suml_s5),
		.in_b      (sumr_s5),
		.in_pay    (pay_s5),
		.out_valid (v_s40),
		.root_a    (left_len),
		.root_b    (right_len),
		.out_pay   (pay_s40)
	);

	// stage 41: vertex tests and opposite slack
	pre_t              pre_v;
	logic [CMP_W-1:0]  lhs_l, rhs_l, lhs_r, rhs_r;
	logic [ROOT_W-1:0] side_len;
	logic [DETA_W-1:0] deta;
	logic              v_s41, prl_s41, prr_s41, reach_s41, dpos_s41;
	logic [FLAGS_W-1:0] flags_s41;
	logic [DMAG_W-1:0] detam_s41;
	logic [SUM_W-1:0]  d2_s41;

	assign pre_v    = pay_s40.pre;
	assign lhs_l    = CMP_W'(pre_v.dl) + CMP_W'(pre_v.pos1);
	assign rhs_l    = CMP_W'(pre_v.root) + CMP_W'(right_len);
	// dr + (L - pos0) < r + leftLen, with pos0 moved across to stay unsigned
	assign lhs_r    = CMP_W'(pre_v.dr) + CMP_W'(pre_v.len);
	assign rhs_r    = CMP_W'(pre_v.root) + CMP_W'(left_len) + CMP_W'(pre_v.pos0);
	assign side_len = pre_v.flags[FLAG_LEFT] ? left_len : right_len;
	assign deta     = DETA_W'(pre_v.root) + DETA_W'(side_len) - DETA_W'(pre_v.dop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s41 <= 1'b0;
		end else if (adv) begin
			v_s41 <= v_s40;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			flags_s41 <= pre_v.flags;
			prl_s41   <= (pre_v.dl < limit_q) && (lhs_l < rhs_l);
			prr_s41   <= (pre_v.dr < limit_q) && (lhs_r < rhs_r);
			reach_s41 <= (pre_v.dop < limit_q);
			dpos_s41  <= !deta[DETA_W-1] && (deta != '0);
			detam_s41 <= deta[DMAG_W-1:0];
			d2_s41    <= pay_s40.d2;
		end
	end

	// stages 42 and 43: slack squared
	logic [DSQ_W-1:0]   detasq;
	logic               v_s42, v_s43;
	logic [FLAGS_W-1:0] flags_s42, flags_s43;
	logic               prl_s42, prl_s43, prr_s42, prr_s43;
	logic               oppv_s42, oppv_s43;
	logic [SUM_W-1:0]   d2_s42, d2_s43;

	gwfc_square #(.W(DMAG_W)) u_sq_deta (.clk(clk), .en(adv), .a(detam_s41), .y(detasq));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s42 <= 1'b0;
			v_s43 <= 1'b0;
		end else if (adv) begin
			v_s42 <= v_s41;
			v_s43 <= v_s42;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			flags_s42 <= flags_s41;
			prl_s42   <= prl_s41;
			prr_s42   <= prr_s41;
			oppv_s42  <= reach_s41 && dpos_s41;
			d2_s42    <= d2_s41;
			flags_s43 <= flags_s42;
			prl_s43   <= prl_s42;
			prr_s43   <= prr_s42;
			oppv_s43  <= oppv_s42;
			d2_s43    <= d2_s42;
		end
	end

	// decision, output register and skid
	logic push, keep_new;
	logic out_valid_q, out_keep_q, skid_keep_q;

	assign push     = adv && v_s43;
	assign keep_new = flags_s43[FLAG_PSEUDO]
		|| !(prl_s43 || prr_s43 || (oppv_s43 && (DSQ_W'(d2_s43) < detasq)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || res.ready) begin
			out_valid_q  <= skid_valid_q || push;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || res.ready) begin
			out_keep_q <= skid_valid_q ? skid_keep_q : keep_new;
		end else if (push) begin
			skid_keep_q <= keep_new;
		end
	end

	assign res.valid       = out_valid_q;
	assign res.keep_window = out_keep_q;

	`ASSERT_IMPLIES(a_skid_needs_out, skid_valid_q, out_valid_q, "skid word held with output empty")
	`ASSERT_NEXT(a_stall_to_skid, out_valid_q && !res.ready && push, skid_valid_q, "stalled word lost")
	`ASSERT_IMPLIES(a_pseudo_keep, push && flags_s43[FLAG_PSEUDO], keep_new, "pseudo source window pruned")

endmodule

`default_nettype wire

// ----- verif/geodesic_window_filter_check_unit_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// geodesic_window_filter_check_unit_test
// checks keep/prune decisions of the window filter against a local predictor
// ----------------------------------------------------------------------------
// Directed corner windows, then random windows under the reset limit and
// several unreached limits written over APB. Both channels stall at random, and once the
// receiver holds off long enough to back up the pipeline.
// ----------------------------------------------------------------------------

module geodesic_window_filter_check_unit_test;
	import gwfc_pkg::*;

	typedef struct {
		logic [FLAGS_W-1:0]        flags;
		logic [LEN_W-1:0]          edge_len;
		logic [PROP_W-1:0]         near_p;
		logic [PROP_W-1:0]         far_p;
		logic signed [COORD_W-1:0] sx;
		logic signed [COORD_W-1:0] sy;
		logic [DIST_W-1:0]         root;
		logic [DIST_W-1:0]         dl;
		logic [DIST_W-1:0]         dr;
		logic [DIST_W-1:0]         dop;
		logic signed [COORD_W-1:0] ox;
		logic signed [COORD_W-1:0] oy;
	} window_t;

	class keep_scoreboard;
		bit          keep_q[$];
		int          errors;
		logic [30:0] limit;

		static function logic [127:0] square(longint v);
			logic [127:0] m;
			m = (v < 0) ? 128'(-v) : 128'(v);
			return m * m;
		endfunction

		static function longint isqrt(logic [127:0] v);
			longint       r;
			logic [127:0] c;
			r = 0;
			for (int b = 35; b >= 0; b--) begin
				c = 128'(r | (longint'(1) << b));
				if (c * c <= v)
					r = longint'(c);
			end
			return r;
		endfunction

		function bit predict_keep(window_t w);
			longint len, pos0, pos1, sx, sy, root, dl, dr, dop, lim;
			longint left_len, right_len, side_len, pos, deta, xv, yv;
			logic [127:0] sy2;
			if (w.flags[FLAG_PSEUDO])
				return 1'b1;
			len = w.edge_len; root = w.root;
			dl = w.dl; dr = w.dr; dop = w.dop; lim = limit;
			sx = w.sx; sy = w.sy;
			pos0 = (longint'(w.near_p) * len) >>> PROP_BITS;
			pos1 = (longint'(w.far_p) * len) >>> PROP_BITS;
			sy2 = square(sy);
			right_len = isqrt(square(sx - pos1) + sy2);
			left_len = isqrt(square(sx - pos0) + sy2);
			if (dl < lim && dl + pos1 < root + right_len)
				return 1'b0;
			if (dr < lim && dr + (len - pos0) < root + left_len)
				return 1'b0;
			if (dop < lim) begin
				xv = len - longint'(w.ox);
				yv = -longint'(w.oy);
				side_len = w.flags[FLAG_LEFT] ? left_len : right_len;
				pos = w.flags[FLAG_LEFT] ? pos0 : pos1;
				deta = root + side_len - dop;
				if (deta > 0 && square(xv - pos) + square(yv) < square(deta))
					return 1'b0;
			end
			return 1'b1;
		endfunction

		function void note_window(window_t w);
			keep_q.push_back(predict_keep(w));
		endfunction

		function void check_keep(bit got);
			bit want;
			if (keep_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result word keep=%0d", got);
				return;
			end
			want = keep_q.pop_front();
			if (want !== got) begin
				errors++;
				if (errors <= 10)
					$display("keep_window mismatch: expected %0d actual %0d", want, got);
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 psel, penable, pwrite;
	logic [PADDR_W-1:0]   paddr;
	logic [PDATA_W-1:0]   pwdata;
	logic [PDATA_W-1:0]   prdata;
	logic                 pready;

	gwfc_win_if win_ch ();
	gwfc_res_if res_ch ();

	geodesic_window_filter_check_unit uut (
		.clk(clk), .arst_n(arst_n), .win(win_ch.sink), .res(res_ch.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	keep_scoreboard sb = new();
	int  moved;
	bit  hold_req;
	bit  win_busy;
	bit  res_busy;

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// ---- window sender
	task automatic send_window(window_t w);
		int gap;
		gap = win_busy ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			win_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		win_ch.valid                <= 1'b1;
		win_ch.window_flags         <= w.flags;
		win_ch.edge_length          <= w.edge_len;
		win_ch.near_proportion      <= w.near_p;
		win_ch.far_proportion       <= w.far_p;
		win_ch.source_x             <= w.sx;
		win_ch.source_y             <= w.sy;
		win_ch.root_distance        <= w.root;
		win_ch.left_vertex_dist     <= w.dl;
		win_ch.right_vertex_dist    <= w.dr;
		win_ch.opposite_vertex_dist <= w.dop;
		win_ch.opposite_x           <= w.ox;
		win_ch.opposite_y           <= w.oy;
		@(posedge clk);
		while (!win_ch.ready) @(posedge clk);
		sb.note_window(w);
		moved++;
	endtask

	// ---- result receiver, own hold-off counter for the backpressure stretch
	initial begin
		int gap;
		res_ch.ready <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				res_ch.ready <= 1'b0;
				repeat (300) @(posedge clk);
				hold_req = 1'b0;
			end
			gap = res_busy ? 0 : $urandom_range(0, 9);
			if (gap > 0) begin
				res_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			@(posedge clk);
			while (!res_ch.valid) @(posedge clk);
			sb.check_keep(res_ch.keep_window);
			moved++;
		end
	end

	// ---- watchdog on cycles without any accepted word
	initial begin
		int last, quiet;
		last = 0;
		quiet = 0;
		forever begin
			@(posedge clk);
			if (moved != last) begin
				last = moved;
				quiet = 0;
			end else if (++quiet >= 5000) begin
				$display("geodesic_window_filter_check_unit_test NOT OK");
				$finish;
			end
		end
	end

	task automatic write_limit(logic [30:0] value);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= ADDR_LIMIT;
		pwdata  <= {1'b0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		sb.limit = value;
	endtask

	// stop offering the last word, then wait for every result
	task automatic wait_drained();
		win_ch.valid <= 1'b0;
		while (sb.keep_q.size() > 0) @(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	function automatic window_t make_window(logic [1:0] f, logic [30:0] len,
			logic [16:0] p0, logic [16:0] p1, int sx, int sy, logic [30:0] root,
			logic [30:0] dl, logic [30:0] dr, logic [30:0] dop, int ox, int oy);
		window_t w;
		w.flags = f; w.edge_len = len; w.near_p = p0; w.far_p = p1;
		w.sx = sx; w.sy = sy; w.root = root; w.dl = dl; w.dr = dr;
		w.dop = dop; w.ox = ox; w.oy = oy;
		return w;
	endfunction

	function automatic window_t random_window();
		window_t     w;
		logic [31:0] scale;
		if ($urandom_range(0, 7) == 0) begin
			// raw bits, proportions may exceed one
			w.flags = FLAGS_W'($urandom); w.edge_len = LEN_W'($urandom);
			w.near_p = PROP_W'($urandom); w.far_p = PROP_W'($urandom);
			w.sx = $urandom; w.sy = $urandom;
			w.root = DIST_W'($urandom); w.dl = DIST_W'($urandom);
			w.dr = DIST_W'($urandom); w.dop = DIST_W'($urandom);
			w.ox = $urandom; w.oy = $urandom;
			return w;
		end
		scale = 32'd1 << $urandom_range(8, 29);
		w.flags = {1'($urandom), ($urandom_range(0, 7) == 0)};
		w.edge_len = LEN_W'($urandom_range(0, scale));
		w.near_p = PROP_W'($urandom_range(0, 65536));
		w.far_p = PROP_W'($urandom_range(w.near_p, 65536));
		w.sx = int'($urandom_range(0, 2 * scale)) - int'(scale);
		w.sy = int'($urandom_range(0, 2 * scale)) - int'(scale);
		w.root = DIST_W'($urandom_range(0, scale));
		w.dl = DIST_W'($urandom_range(0, 2 * scale));
		w.dr = DIST_W'($urandom_range(0, 2 * scale));
		w.dop = DIST_W'($urandom_range(0, 2 * scale));
		w.ox = int'($urandom_range(0, 2 * scale)) - int'(scale);
		w.oy = int'($urandom_range(0, 2 * scale)) - int'(scale);
		return w;
	endfunction

	task automatic random_phase(int count, bit with_hold);
		for (int i = 0; i < count; i++) begin
			if (i % 100 == 0) begin
				win_busy = ($urandom_range(0, 3) == 0);
				res_busy = ($urandom_range(0, 3) == 0);
			end
			if (with_hold && i == 20)
				hold_req = 1'b1;
			send_window(random_window());
		end
		win_busy = 1'b1;
	endtask

	localparam int ONE = 65536;

	initial begin
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		win_ch.valid = 1'b0;
		{win_ch.window_flags, win_ch.edge_length, win_ch.near_proportion,
		 win_ch.far_proportion, win_ch.source_x, win_ch.source_y,
		 win_ch.root_distance, win_ch.left_vertex_dist, win_ch.right_vertex_dist,
		 win_ch.opposite_vertex_dist, win_ch.opposite_x, win_ch.opposite_y} = '0;
		moved = 0; hold_req = 1'b0; win_busy = 1'b0; res_busy = 1'b0;
		sb.limit = LIMIT_RESET;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// corner windows under the reset limit
		send_window(make_window(2'b11, '1, '1, '1, -1, -1, '1, 0, 0, 0, 0, 0));
		send_window(make_window(2'b01, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_window(make_window(2'b00, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_window(make_window(2'b00, '1, ONE, ONE, 32'h7fffffff, 32'h80000000,
			'1, '1, '1, '1, 32'h80000000, 32'h7fffffff));
		send_window(make_window(2'b10, '1, '1, '1, 32'h80000000, 32'h7fffffff,
			'1, 31'h7fff, 31'h7fff, 31'h7fff, 32'h7fffffff, 32'h80000000));
		// left vertex prunes: reached and cheaper than the far end
		send_window(make_window(2'b00, ONE * 10, 0, ONE, 0, ONE * 5, ONE, 0,
			'1, '1, 0, 0));
		// right vertex prunes
		send_window(make_window(2'b00, ONE * 10, 0, ONE, ONE * 10, ONE * 5, ONE,
			'1, 0, '1, 0, 0));
		// opposite vertex prunes, both sides of the parent edge
		send_window(make_window(2'b00, ONE * 10, 0, ONE, ONE * 5, ONE * 5, ONE * 2,
			'1, '1, 0, ONE * 5, -ONE * 4));
		send_window(make_window(2'b10, ONE * 10, 0, ONE, ONE * 5, ONE * 5, ONE * 2,
			'1, '1, 0, ONE * 5, -ONE * 4));
		// slack not positive keeps the window
		send_window(make_window(2'b00, ONE * 10, 0, ONE, ONE * 5, ONE, 0,
			'1, '1, ONE * 100, ONE * 5, -ONE));
		send_window(make_window(2'b10, ONE * 10, ONE / 2, ONE / 2, ONE * 5, 0, 0,
			'1, '1, ONE * 5, ONE * 5, 0));
		// proportions above one push the near end past the edge
		send_window(make_window(2'b00, ONE * 10, 17'h1ffff, 17'h1ffff, 0, ONE,
			ONE, ONE * 3, ONE * 3, ONE * 3, ONE, ONE));
		send_window(make_window(2'b10, ONE * 10, 17'h1ffff, 0, ONE * 20, -ONE,
			ONE, '1, 0, ONE, -ONE, ONE));
		// distances exactly at the limit count as not reached
		send_window(make_window(2'b00, ONE * 10, 0, ONE, 0, 0, ONE * 100,
			LIMIT_RESET, LIMIT_RESET, LIMIT_RESET, 0, 0));
		send_window(make_window(2'b00, ONE * 10, 0, ONE, 0, 0, ONE * 100,
			LIMIT_RESET - 1, LIMIT_RESET - 1, LIMIT_RESET - 1, 0, 0));
		random_phase(450, 1'b1);
		wait_drained();

		write_limit(31'd0);
		random_phase(200, 1'b0);
		wait_drained();

		write_limit(31'h7fffffff);
		send_window(make_window(2'b00, '1, ONE, ONE, 32'h7fffffff, 0, '1,
			31'h7ffffffe, 31'h7ffffffe, 31'h7ffffffe, 32'h80000000, 0));
		random_phase(400, 1'b0);
		wait_drained();

		write_limit(31'($urandom));
		random_phase(250, 1'b0);
		wait_drained();

		write_limit(31'($urandom_range(ONE, ONE * 4096)));
		random_phase(280, 1'b0);
		wait_drained();

		if (sb.errors == 0 && sb.keep_q.size() == 0) begin
			$display("geodesic_window_filter_check_unit_test OK");
		end else begin
			$display("geodesic_window_filter_check_unit_test NOT OK");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/gwfc_pkg.sv
rtl/gwfc_win_if.sv
rtl/gwfc_res_if.sv
rtl/gwfc_square.sv
rtl/gwfc_isqrt2.sv
rtl/geodesic_window_filter_check_unit.sv
verif/geodesic_window_filter_check_unit_test.sv
